// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants
// Word layouts of the input and result channels, register widths and resets.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int TASK_COUNT_DEF = 16;
    localparam int IDX_W          = 4;
    localparam int SLICE_W        = 8;
    localparam int PERIOD_W       = 16;
    localparam int TICK_W         = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   task_index;
        logic               task_ready;
        logic [SLICE_W-1:0] slice_length;
        logic               reentered;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   running_task;
        logic               switched;
        logic [SLICE_W-1:0] remaining_ticks;
        logic [TICK_W-1:0]  tick_total;
    } t_out_word;

endpackage

// ===== hdl/rrts_if.sv =====
// ----------------------------------------------------------------------------
// rrts_if: valid/ready channels
// One interface for the input words and one for the result words.
// ----------------------------------------------------------------------------
interface rrts_in_if;
    logic             valid;
    logic             ready;
    rrts_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrts_out_if;
    logic              valid;
    logic              ready;
    rrts_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/round_robin_time_slice_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler
// Write word: read the current entry, then emit the result. Tick word: decrement
// the current entry, then read it back. Each pick adds one scan pass and, if nothing is runnable,
// one refill pass; a tick may pick twice (period expiry, then slice end).
// One word in flight; the table memory's single read port sets the pace.
// Sync active-low reset clears all control state and the entry valid bits.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_top #(
    parameter int TASK_COUNT = rrts_pkg::TASK_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrts_pkg::PERIOD_W-1:0] i_cfg_wdata,
    rrts_in_if.sink                       i_in,
    rrts_out_if.source                    o_out
);

    localparam int IW = $clog2(TASK_COUNT);
    localparam int CW = $clog2(TASK_COUNT + 1);
    localparam int SW = rrts_pkg::SLICE_W;

    typedef struct packed {
        logic [SW-1:0] slice;
        logic [SW-1:0] ticks;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FILL, S_DEC_RD, S_DEC_WR, S_CUR_RD, S_OUT
    } t_state;

    t_state                        r_state;
    logic [rrts_pkg::PERIOD_W-1:0] r_period;
    logic [rrts_pkg::PERIOD_W-1:0] r_cd;
    logic [rrts_pkg::TICK_W-1:0]   r_tick;
    logic [IW-1:0]                 r_cur;
    logic [IW-1:0]                 r_before;
    logic [IW-1:0]                 r_start;
    logic [IW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_cnt;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_rd_live;
    logic                          r_found;
    logic [IW-1:0]                 r_hit;
    logic                          r_second;
    logic                          r_reent;
    logic                          r_rdy [TASK_COUNT];
    logic                          r_vld [TASK_COUNT];
    t_entry                        r_mem [TASK_COUNT];
    t_entry                        r_rd_data;
    logic                          r_out_valid;
    rrts_pkg::t_out_word           r_out;

    logic          w_accept;
    logic          w_wr_ok;
    logic [IW-1:0] w_widx;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_issue;
    logic          w_done;
    logic          w_hit;
    logic          w_fill_act;
    logic [SW-1:0] w_cur_ticks;
    logic [SW-1:0] w_dec_ticks;
    t_state        w_ret;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] x);
        return (x == IW'(TASK_COUNT - 1)) ? '0 : x + 1'b1;
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_widx   = IW'(i_in.data.task_index);
    assign w_wr_ok  = (int'(i_in.data.task_index) < TASK_COUNT);

    // scan/fill: one read issued per cycle, checked in the next cycle
    assign w_issue    = (r_cnt != CW'(TASK_COUNT));
    assign w_done     = !w_issue && !r_rd_live;
    assign w_hit      = r_rd_live && r_rdy[r_rd_idx] && (r_rd_data.ticks != '0);
    assign w_fill_act = r_rd_live && r_rdy[r_rd_idx];

    // never-written entries read as zero
    assign w_cur_ticks = r_vld[r_cur] ? r_rd_data.ticks : '0;
    assign w_dec_ticks = (w_cur_ticks != '0) ? w_cur_ticks - 1'b1 : '0;
    assign w_ret       = r_second ? S_CUR_RD : S_DEC_RD;

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_cur;
        w_wdata   = '{slice: r_rd_data.slice, ticks: w_dec_ticks};
        w_rd_en   = 1'b0;
        w_rd_addr = r_cur;
        case (r_state)
            S_IDLE: begin
                w_we    = w_accept && (i_in.data.mode == rrts_pkg::MODE_WRITE) && w_wr_ok;
                w_waddr = w_widx;
                w_wdata = '{slice: i_in.data.slice_length, ticks: i_in.data.slice_length};
            end
            S_SCAN: begin
                w_rd_en   = w_issue;
                w_rd_addr = r_ptr;
            end
            S_FILL: begin
                w_rd_en   = w_issue;
                w_rd_addr = r_ptr;
                w_we      = w_fill_act;
                w_waddr   = r_rd_idx;
                w_wdata   = '{slice: r_rd_data.slice, ticks: r_rd_data.slice};
            end
            S_DEC_RD: w_rd_en = 1'b1;
            S_DEC_WR: w_we = (w_cur_ticks != '0);
            S_CUR_RD: w_rd_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= rrts_pkg::PERIOD_RESET;
            r_cd        <= rrts_pkg::PERIOD_RESET;
            r_tick      <= '0;
            r_cur       <= '0;
            r_before    <= '0;
            r_start     <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_rd_idx    <= '0;
            r_rd_live   <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= '0;
            r_second    <= 1'b0;
            r_reent     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            for (int k = 0; k < TASK_COUNT; k++) begin
                r_rdy[k] <= 1'b0;
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_before <= r_cur;
                        r_reent  <= i_in.data.reentered;
                        if (i_in.data.mode == rrts_pkg::MODE_WRITE) begin
                            if (w_wr_ok) begin
                                r_vld[w_widx] <= 1'b1;
                                r_rdy[w_widx] <= i_in.data.task_ready;
                            end
                            r_state <= S_CUR_RD;
                        end else begin
                            r_tick <= r_tick + 1'b1;
                            if (r_cd <= rrts_pkg::PERIOD_W'(1)) begin
                                // period expired: forced pick before the decrement
                                r_cd      <= r_period;
                                r_second  <= 1'b0;
                                r_ptr     <= r_start;
                                r_cnt     <= '0;
                                r_rd_live <= 1'b0;
                                r_state   <= S_SCAN;
                            end else begin
                                r_cd    <= r_cd - 1'b1;
                                r_state <= S_DEC_RD;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_idx  <= r_ptr;
                    r_rd_live <= w_issue;
                    if (w_issue) begin
                        r_ptr <= f_next(r_ptr);
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_hit) begin
                        r_cur   <= r_rd_idx;
                        r_start <= f_next(r_rd_idx);
                        r_state <= w_ret;
                    end else if (w_done) begin
                        r_ptr     <= '0;
                        r_cnt     <= '0;
                        r_rd_live <= 1'b0;
                        r_found   <= 1'b0;
                        r_state   <= S_FILL;
                    end
                end
                S_FILL: begin
                    // refill and find the first runnable entry in one pass
                    r_rd_idx  <= r_ptr;
                    r_rd_live <= w_issue;
                    if (w_issue) begin
                        r_ptr <= f_next(r_ptr);
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_fill_act && !r_found && (r_rd_data.slice != '0)) begin
                        r_found <= 1'b1;
                        r_hit   <= r_rd_idx;
                    end
                    if (w_done) begin
                        if (r_found) begin
                            r_cur   <= r_hit;
                            r_start <= f_next(r_hit);
                        end else begin
                            r_start <= '0;
                        end
                        r_state <= w_ret;
                    end
                end
                S_DEC_RD: r_state <= S_DEC_WR;
                S_DEC_WR: begin
                    if (!r_reent && (w_dec_ticks == '0)) begin
                        r_second  <= 1'b1;
                        r_ptr     <= r_start;
                        r_cnt     <= '0;
                        r_rd_live <= 1'b0;
                        r_state   <= S_SCAN;
                    end else begin
                        r_state <= S_CUR_RD;
                    end
                end
                S_CUR_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid           <= 1'b1;
                        r_out.running_task    <= rrts_pkg::IDX_W'(r_cur);
                        r_out.switched        <= (r_cur != r_before);
                        r_out.remaining_ticks <= w_cur_ticks;
                        r_out.tick_total      <= r_tick;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_start) < TASK_COUNT)
        else $error("search start out of table");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= TASK_COUNT)
        else $error("scan count overrun");

    a_fill_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && w_we) |-> (r_rd_live && r_rdy[r_rd_idx]))
        else $error("refill wrote a stale or unready entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("second word taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> $stable(r_out))
        else $error("pending result overwritten");

endmodule

// ===== tb/round_robin_time_slice_scheduler_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler testbench
// Drives write and tick words, predicts the scheduler state in a local model
// of the task table and checks every result word in order. Runs directed
// table setups, period extremes, random traffic under several idle and stall
// mixes, and a long receiver hold that backs up the input channel.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_top_test;

    localparam int TASKS = rrts_pkg::TASK_COUNT_DEF;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [rrts_pkg::PERIOD_W-1:0] i_cfg_wdata;

    rrts_in_if  in_if ();
    rrts_out_if out_if ();

    round_robin_time_slice_scheduler_top #(
        .TASK_COUNT (TASKS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // local copy of the scheduler state
    logic [rrts_pkg::TICK_W-1:0]   tick_cnt;
    logic [rrts_pkg::PERIOD_W-1:0] period_reg;
    logic [rrts_pkg::PERIOD_W-1:0] countdown;
    int                            scan_from;
    int                            cur_task;
    logic                          ready_mark [TASKS];
    logic [rrts_pkg::SLICE_W-1:0]  ticks_rem  [TASKS];
    logic [rrts_pkg::SLICE_W-1:0]  slice_len  [TASKS];

    rrts_pkg::t_out_word pending_schedules [$];
    int                  mismatch_count = 0;
    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    int                  hold_len  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void reset_table_model();
        tick_cnt   = '0;
        period_reg = rrts_pkg::PERIOD_RESET;
        countdown  = rrts_pkg::PERIOD_RESET;
        scan_from  = 0;
        cur_task   = 0;
        for (int k = 0; k < TASKS; k++) begin
            ready_mark[k] = 1'b0;
            ticks_rem[k]  = '0;
            slice_len[k]  = '0;
        end
    endfunction

    function automatic int find_runnable(input int first);
        int idx;
        for (int k = 0; k < TASKS; k++) begin
            idx = (first + k) % TASKS;
            if (ready_mark[idx] && ticks_rem[idx] != 0) return idx;
        end
        return -1;
    endfunction

    function automatic void pick_next_task();
        int hit;
        hit = find_runnable(scan_from);
        if (hit < 0) begin
            // nothing runnable: refill every ready entry, rescan from the head
            for (int k = 0; k < TASKS; k++)
                if (ready_mark[k]) ticks_rem[k] = slice_len[k];
            hit = find_runnable(0);
        end
        if (hit < 0) begin
            scan_from = 0;
        end else begin
            cur_task  = hit;
            scan_from = (hit + 1) % TASKS;
        end
    endfunction

    function automatic rrts_pkg::t_out_word predict_schedule(input rrts_pkg::t_in_word w);
        rrts_pkg::t_out_word r;
        int                  prev;
        prev = cur_task;
        if (w.mode == rrts_pkg::MODE_WRITE) begin
            ready_mark[w.task_index] = w.task_ready;
            slice_len[w.task_index]  = w.slice_length;
            ticks_rem[w.task_index]  = w.slice_length;
        end else begin
            tick_cnt = tick_cnt + 1'b1;
            if (countdown <= 1) begin
                pick_next_task();
                countdown = period_reg;
            end else begin
                countdown = countdown - 1'b1;
            end
            if (ticks_rem[cur_task] != 0) ticks_rem[cur_task] = ticks_rem[cur_task] - 1'b1;
            if (!w.reentered && ticks_rem[cur_task] == 0) pick_next_task();
        end
        r.running_task    = rrts_pkg::IDX_W'(cur_task);
        r.switched        = (cur_task != prev);
        r.remaining_ticks = ticks_rem[cur_task];
        r.tick_total      = tick_cnt;
        return r;
    endfunction

    // result side: check on accepted words, then drive ready for the next edge
    initial begin
        rrts_pkg::t_out_word want;
        rrts_pkg::t_out_word got;
        int                  hold_cnt;
        hold_cnt = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) begin
                got = out_if.data;
                if (pending_schedules.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = pending_schedules.pop_front();
                    if (got.running_task !== want.running_task) begin
                        $error("running_task: expected %0d, got %0d",
                               want.running_task, got.running_task);
                        mismatch_count++;
                    end
                    if (got.switched !== want.switched) begin
                        $error("switched: expected %0d, got %0d", want.switched, got.switched);
                        mismatch_count++;
                    end
                    if (got.remaining_ticks !== want.remaining_ticks) begin
                        $error("remaining_ticks: expected %0d, got %0d",
                               want.remaining_ticks, got.remaining_ticks);
                        mismatch_count++;
                    end
                    if (got.tick_total !== want.tick_total) begin
                        $error("tick_total: expected %0d, got %0d",
                               want.tick_total, got.tick_total);
                        mismatch_count++;
                    end
                end
            end
            if (hold_len > 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input rrts_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_schedules.push_back(predict_schedule(w));
    endtask

    task automatic send_write(input int idx, input logic rdy, input int slice);
        rrts_pkg::t_in_word w;
        w.mode         = rrts_pkg::MODE_WRITE;
        w.task_index   = rrts_pkg::IDX_W'(idx);
        w.task_ready   = rdy;
        w.slice_length = rrts_pkg::SLICE_W'(slice);
        w.reentered    = 1'b0;
        send_word(w);
    endtask

    task automatic send_tick(input logic reent);
        rrts_pkg::t_in_word w;
        w.mode         = rrts_pkg::MODE_TICK;
        w.task_index   = rrts_pkg::IDX_W'($urandom_range(15));
        w.task_ready   = 1'($urandom_range(1));
        w.slice_length = rrts_pkg::SLICE_W'($urandom_range(255));
        w.reentered    = reent;
        send_word(w);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_schedules.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input int value);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rrts_pkg::PERIOD_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        period_reg  = rrts_pkg::PERIOD_W'(value);
    endtask

    function automatic rrts_pkg::t_in_word random_sched_word();
        rrts_pkg::t_in_word w;
        w.task_index   = rrts_pkg::IDX_W'($urandom_range(15));
        w.task_ready   = 1'($urandom_range(1));
        w.slice_length = rrts_pkg::SLICE_W'($urandom_range(255));
        w.reentered    = 1'($urandom_range(1));
        if ($urandom_range(99) < 35) begin
            w.mode       = rrts_pkg::MODE_WRITE;
            w.task_ready = ($urandom_range(3) != 0);
            // short slices keep expiries and refills frequent
            if ($urandom_range(9) != 0) w.slice_length = rrts_pkg::SLICE_W'($urandom_range(6));
        end else begin
            w.mode      = rrts_pkg::MODE_TICK;
            w.reentered = ($urandom_range(6) == 0);
        end
        return w;
    endfunction

    task automatic test_directed_table();
        send_tick(1'b0);            // empty table, pick finds nothing
        send_write(0, 1'b1, 0);     // ready but zero slice
        send_tick(1'b0);
        send_write(15, 1'b1, 255);
        send_write(3, 1'b1, 2);
        send_write(4, 1'b0, 5);
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_write(10, 1'b1, 'h55);
        send_write(5, 1'b1, 'hAA);
        repeat (3) send_tick(1'b0);
        // single ready task with a nonzero slice: refill reselects it
        send_write(15, 1'b0, 0);
        send_write(10, 1'b0, 0);
        send_write(5, 1'b0, 1);
        send_write(3, 1'b1, 1);
        repeat (4) send_tick(1'b0);
    endtask

    task automatic test_period_extremes();
        write_period(0);
        send_write(7, 1'b1, 3);
        send_write(8, 1'b1, 1);
        repeat (5) send_tick(1'b0);
        write_period(65535);
        repeat (5) send_tick(1'b0);
        write_period(1);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    task automatic test_random_traffic(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_word(random_sched_word());
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(posedge i_clk);
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = 400;
        repeat (30) send_word(random_sched_word());
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        reset_table_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_table();
        test_period_extremes();
        write_period(3);
        test_random_traffic(400, 0, 0);
        write_period(0);
        test_random_traffic(350, 49, 0);
        write_period(65535);
        test_random_traffic(350, 0, 49);
        write_period(1);
        test_random_traffic(350, 17, 17);
        write_period(10);
        test_backpressure();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
